FILE: hw/rtl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg
// Shared types and constants of the STUN message parser.
// ----------------------------------------------------------------------------
`default_nettype none
package smp_pkg;

    localparam int STRING_MAX_DEF  = 128;
    localparam int MAX_ATTRIBS_DEF = 16;

    localparam logic [31:0] COOKIE = 32'h2112_A442;

    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_AHDR = 3'd1;
    localparam logic [2:0] PH_VAL  = 3'd2;
    localparam logic [2:0] PH_PAD  = 3'd3;
    localparam logic [2:0] PH_DROP = 3'd4;

    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_ATTR = 2'd1;
    localparam logic [1:0] KIND_PAY  = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_HDRBITS  = 3'd2;
    localparam logic [2:0] ST_COOKIE   = 3'd3;
    localparam logic [2:0] ST_OVERLONG = 3'd4;
    localparam logic [2:0] ST_AHDR_CUT = 3'd5;
    localparam logic [2:0] ST_INVALID  = 3'd6;
    localparam logic [2:0] ST_VAL_CUT  = 3'd7;

    localparam logic [15:0] AT_MAPPED   = 16'h0001;
    localparam logic [15:0] AT_XPEER    = 16'h0012;
    localparam logic [15:0] AT_XRELAY   = 16'h0016;
    localparam logic [15:0] AT_XMAPPED  = 16'h0020;
    localparam logic [15:0] AT_USER     = 16'h0006;
    localparam logic [15:0] AT_REALM    = 16'h0014;
    localparam logic [15:0] AT_NONCE    = 16'h0015;
    localparam logic [15:0] AT_SOFTWARE = 16'h8022;
    localparam logic [15:0] AT_ERROR    = 16'h0009;
    localparam logic [15:0] AT_FPRINT   = 16'h8028;
    localparam logic [15:0] AT_PRIORITY = 16'h0024;
    localparam logic [15:0] AT_LIFETIME = 16'h000D;
    localparam logic [15:0] AT_REQTRANS = 16'h0019;
    localparam logic [15:0] AT_MSGINT   = 16'h0008;
    localparam logic [15:0] AT_ICECTL   = 16'h802A;
    localparam logic [15:0] AT_ICECTD   = 16'h8029;
    localparam logic [15:0] AT_USECAND  = 16'h0025;
    localparam logic [15:0] AT_DATA     = 16'h0013;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] type_code;
        logic [15:0] length_field;
        logic [7:0]  family;
        logic [15:0] port;
        logic [63:0] value_high;
        logic [63:0] value_low;
        logic [7:0]  payload_byte;
        logic        stored;
        logic [2:0]  status;
        logic        last;
    } out_item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/stun_message_parser_top.sv
// ----------------------------------------------------------------------------
// stun_message_parser_top
// Byte-wide STUN message parser: header checks, attribute decoding, status.
// ----------------------------------------------------------------------------
// Results are registered and appear in the cycle after their byte is accepted.
// Throughput: one byte per cycle while results drain; a byte yields up to
// three results, which leave one per cycle from a small result queue when
// the output is not stalled, so bytes causing several results hold the input.
// Reset: asynchronous, active low; the parser returns to the header phase.
// ----------------------------------------------------------------------------
`default_nettype none
module stun_message_parser_top #(
    parameter int STRING_MAX  = smp_pkg::STRING_MAX_DEF,
    parameter int MAX_ATTRIBS = smp_pkg::MAX_ATTRIBS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire smp_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output smp_pkg::out_item_t      out_data
);
    import smp_pkg::*;

    localparam int CW = $clog2(MAX_ATTRIBS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ATTRIBS);
    localparam logic [15:0] STR_LIM = 16'(STRING_MAX - 1);

    // Parser state.
    logic [15:0] pos_reg, pos_next;
    logic [2:0]  phase_reg, phase_next;
    logic [13:0] mtype_reg, mtype_next;
    logic [15:0] dlen_reg, dlen_next;
    logic [31:0] cookie_reg, cookie_next;
    logic [31:0] txu_reg, txu_next;
    logic [63:0] txl_reg, txl_next;
    logic [15:0] atype_reg, atype_next;
    logic [15:0] alen_reg, alen_next;
    logic [15:0] aoff_reg, aoff_next;
    logic [63:0] acch_reg, acch_next;
    logic [63:0] accl_reg, accl_next;
    logic [1:0]  pad_reg, pad_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        fail_reg, fail_next;

    // Result queue of three entries; bytes are taken only when it is empty
    // enough to hold every result a byte might cause.
    out_item_t   q_reg [3];
    out_item_t   q_next [3];
    logic [1:0]  qn_reg, qn_next;

    out_item_t   res [3];
    logic [1:0]  nres;

    logic [7:0]  b;
    logic        lb;
    logic        accept;
    logic        deq;

    // Attribute decode inputs, with this byte folded in.
    logic [15:0] d_type, d_len;
    logic [31:0] d_w0;
    logic [63:0] d_ah, d_al;
    out_item_t   d_item;
    logic        d_bad;

    smp_attr_decode #(.STRING_MAX(STRING_MAX)) u_dec (
        .attr_type (d_type),
        .attr_len  (d_len),
        .word0     (d_w0),
        .acc_high  (d_ah),
        .acc_low   (d_al),
        .txid_upper(txu_reg),
        .txid_lower(txl_reg),
        .item      (d_item),
        .bad       (d_bad)
    );

    assign out_valid = (qn_reg != 2'd0);
    assign out_data  = q_reg[0];
    assign deq       = out_valid && !out_stall;
    // Room for three results after this cycle's dequeue.
    assign in_stall  = !(qn_reg == 2'd0 || (qn_reg == 2'd1 && deq));
    assign accept    = in_valid && !in_stall;
    assign b  = in_data.data_byte;
    assign lb = in_data.last_byte;

    function automatic out_item_t end_item(input logic [2:0] code);
        out_item_t r;
        r = '0;
        r.result_kind = KIND_END;
        r.status = code;
        return r;
    endfunction

    always_comb
    begin
        logic [15:0] p;
        logic [15:0] o;
        logic [15:0] on;
        logic [31:0] ck;
        logic        pass;
        out_item_t   attr_r;
        out_item_t   pay;

        p = '0; o = '0; on = '0; ck = '0; pass = 1'b0; attr_r = '0; pay = '0;
        pos_next = pos_reg; phase_next = phase_reg; mtype_next = mtype_reg;
        dlen_next = dlen_reg; cookie_next = cookie_reg; txu_next = txu_reg;
        txl_next = txl_reg; atype_next = atype_reg; alen_next = alen_reg;
        aoff_next = aoff_reg; acch_next = acch_reg; accl_next = accl_reg;
        pad_next = pad_reg; cnt_next = cnt_reg; fail_next = fail_reg;
        res[0] = '0; res[1] = '0; res[2] = '0;
        nres = 2'd0;
        d_type = atype_reg; d_len = alen_reg; d_w0 = cookie_reg;
        d_ah = acch_reg; d_al = accl_reg;

        // Attribute finished: decode result and counting.
        attr_r = d_item;
        attr_r.stored = 1'b0;

        if (phase_reg == PH_DROP || phase_reg > PH_DROP)
        begin
            if (lb)
            begin
                phase_next = PH_HDR;
                pos_next = '0;
            end
        end
        else if (phase_reg == PH_HDR)
        begin
            p = (pos_reg > 16'd19) ? 16'd19 : pos_reg;
            if (p == 16'd0)
            begin
                mtype_next = '0; dlen_next = '0; cookie_next = '0;
                txu_next = '0; txl_next = '0; cnt_next = '0; fail_next = 1'b0;
            end
            ck = (p == 16'd0) ? 32'd0 : cookie_reg;
            if (lb && p < 16'd19)
            begin
                res[0] = end_item(ST_SHORT); nres = 2'd1;
                phase_next = PH_HDR; pos_next = '0;
            end
            else if (p == 16'd0 && (b & 8'hC0) != 8'd0)
            begin
                res[0] = end_item(ST_HDRBITS); nres = 2'd1;
                phase_next = PH_DROP; pos_next = '0;
            end
            else
            begin
                if (p == 16'd0)
                    mtype_next = {b[5:0], 8'd0};
                else if (p == 16'd1)
                    mtype_next = mtype_reg | {6'd0, b};
                else if (p == 16'd2)
                    dlen_next = {b, 8'd0};
                else if (p == 16'd3)
                    dlen_next = dlen_reg | {8'd0, b};
                else if (p < 16'd8)
                begin
                    ck = cookie_reg | ({24'd0, b} << {p[1:0] ^ 2'd3, 3'd0});
                    cookie_next = ck;
                end
                else if (p < 16'd12)
                    txu_next = txu_reg | ({24'd0, b} << {p[1:0] ^ 2'd3, 3'd0});
                else
                    txl_next = txl_reg | ({56'd0, b} << {3'd3 - 3'(p - 16'd12) + 3'd4, 3'd0});
                if (p == 16'd7 && ck != COOKIE)
                begin
                    res[0] = end_item(ST_COOKIE); nres = 2'd1;
                    phase_next = PH_DROP; pos_next = '0;
                end
                else if (p < 16'd19)
                    pos_next = p + 16'd1;
                else
                begin
                    res[0] = '0;
                    res[0].result_kind = KIND_HDR;
                    res[0].type_code = {2'd0, mtype_reg};
                    res[0].length_field = dlen_reg;
                    res[0].value_high = {32'd0, txu_reg};
                    res[0].value_low = txl_next;
                    nres = 2'd1;
                    phase_next = PH_AHDR; pos_next = '0; aoff_next = '0;
                    if (lb)
                    begin
                        res[1] = end_item(ST_OK); nres = 2'd2;
                        phase_next = PH_HDR;
                    end
                end
            end
        end
        else if (pos_reg >= dlen_reg)
        begin
            res[0] = end_item(ST_OVERLONG); nres = 2'd1;
            phase_next = lb ? PH_HDR : PH_DROP; pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 16'd1;
            if (phase_reg == PH_AHDR)
            begin
                case (aoff_reg[1:0])
                    2'd0: atype_next = {b, 8'd0};
                    2'd1: atype_next = atype_reg | {8'd0, b};
                    2'd2: alen_next = {b, 8'd0};
                    default: alen_next = alen_reg | {8'd0, b};
                endcase
                if (aoff_reg[1:0] != 2'd3)
                begin
                    aoff_next = {14'd0, aoff_reg[1:0] + 2'd1};
                    if (lb)
                    begin
                        res[0] = end_item(ST_AHDR_CUT); nres = 2'd1;
                        phase_next = PH_HDR; pos_next = '0;
                    end
                end
                else
                begin
                    aoff_next = '0; cookie_next = '0; acch_next = '0; accl_next = '0;
                    d_type = atype_reg; d_len = alen_next;
                    d_w0 = '0; d_ah = '0; d_al = '0;
                    if (alen_next == 16'd0)
                    begin
                        attr_r = d_item;
                        attr_r.stored = !d_bad && (cnt_reg < CNT_MAX);
                        if (attr_r.stored)
                            cnt_next = cnt_reg + CW'(1);
                        fail_next = d_bad;
                        res[0] = attr_r; nres = 2'd1;
                        if (lb)
                        begin
                            res[1] = end_item(d_bad ? ST_INVALID : ST_OK); nres = 2'd2;
                            phase_next = PH_HDR; pos_next = '0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_VAL;
                        if (lb)
                        begin
                            res[0] = end_item(ST_VAL_CUT); nres = 2'd1;
                            phase_next = PH_HDR; pos_next = '0;
                        end
                    end
                end
            end
            else if (phase_reg == PH_VAL)
            begin
                o = aoff_reg;
                if (o < 16'd4)
                    cookie_next = cookie_reg | ({24'd0, b} << {o[1:0] ^ 2'd3, 3'd0});
                else if (o < 16'd12)
                    acch_next = acch_reg | ({56'd0, b} << {3'(16'd11 - o), 3'd0});
                else if (o < 16'd20)
                    accl_next = accl_reg | ({56'd0, b} << {3'(16'd19 - o), 3'd0});
                case (atype_reg)
                    AT_USER, AT_REALM, AT_NONCE, AT_SOFTWARE:
                        pass = (o < STR_LIM);
                    AT_ERROR:
                        pass = (o >= 16'd4) && ((o - 16'd4) < STR_LIM);
                    AT_MSGINT, AT_DATA:
                        pass = 1'b1;
                    default:
                        pass = 1'b0;
                endcase
                pay = '0;
                pay.result_kind = KIND_PAY;
                pay.type_code = atype_reg;
                pay.length_field = alen_reg;
                pay.payload_byte = b;
                if (pass)
                begin
                    res[0] = pay; nres = 2'd1;
                end
                on = o + 16'd1;
                aoff_next = on;
                if (on < alen_reg)
                begin
                    if (lb)
                    begin
                        res[nres] = end_item(ST_VAL_CUT); nres = nres + 2'd1;
                        phase_next = PH_HDR; pos_next = '0;
                    end
                end
                else
                begin
                    aoff_next = '0;
                    d_w0 = cookie_next; d_ah = acch_next; d_al = accl_next;
                    attr_r = d_item;
                    attr_r.stored = !d_bad && (cnt_reg < CNT_MAX);
                    if (attr_r.stored)
                        cnt_next = cnt_reg + CW'(1);
                    fail_next = d_bad;
                    res[nres] = attr_r; nres = nres + 2'd1;
                    pad_next = 2'd0 - alen_reg[1:0];
                    phase_next = (alen_reg[1:0] != 2'd0) ? PH_PAD : PH_AHDR;
                    if (lb)
                    begin
                        res[nres] = end_item(d_bad ? ST_INVALID : ST_OK);
                        nres = nres + 2'd1;
                        phase_next = PH_HDR; pos_next = '0;
                    end
                end
            end
            else
            begin
                pad_next = (pad_reg != 2'd0) ? pad_reg - 2'd1 : pad_reg;
                if (pad_next == 2'd0)
                    phase_next = PH_AHDR;
                if (lb)
                begin
                    res[0] = end_item(fail_reg ? ST_INVALID : ST_OK); nres = 2'd1;
                    phase_next = PH_HDR; pos_next = '0;
                end
            end
        end
        if (nres != 2'd0)
            res[nres - 2'd1].last = 1'b1;
    end

    // Queue update.
    always_comb
    begin
        logic [1:0] base;
        base = qn_reg;
        q_next[0] = q_reg[0]; q_next[1] = q_reg[1]; q_next[2] = q_reg[2];
        if (deq)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            base = qn_reg - 2'd1;
        end
        qn_next = base;
        if (accept)
        begin
            // base is zero whenever a byte is accepted.
            q_next[0] = res[0];
            q_next[1] = res[1];
            q_next[2] = res[2];
            qn_next = nres;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; phase_reg <= PH_HDR; mtype_reg <= '0; dlen_reg <= '0;
            cookie_reg <= '0; txu_reg <= '0; txl_reg <= '0; atype_reg <= '0;
            alen_reg <= '0; aoff_reg <= '0; acch_reg <= '0; accl_reg <= '0;
            pad_reg <= '0; cnt_reg <= '0; fail_reg <= 1'b0; qn_reg <= '0;
        end
        else
        begin
            qn_reg <= qn_next;
            if (accept)
            begin
                pos_reg <= pos_next; phase_reg <= phase_next; mtype_reg <= mtype_next;
                dlen_reg <= dlen_next; cookie_reg <= cookie_next; txu_reg <= txu_next;
                txl_reg <= txl_next; atype_reg <= atype_next; alen_reg <= alen_next;
                aoff_reg <= aoff_next; acch_reg <= acch_next; accl_reg <= accl_next;
                pad_reg <= pad_next; cnt_reg <= cnt_next; fail_reg <= fail_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
        q_reg[2] <= q_next[2];
    end

    // The queue never overfills and input is held while it is busy.
    assert property (@(posedge clk) disable iff (!rst_n) qn_reg != 2'd3 || in_stall)
        else $error("byte accepted with a full result queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (qn_reg == $past(nres)))
        else $error("result count lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && qn_reg == 2'd1 && !out_stall && !in_valid) |=> !out_valid)
        else $error("result repeated");

endmodule
`default_nettype wire

FILE: hw/rtl/smp_attr_decode.sv
// ----------------------------------------------------------------------------
// smp_attr_decode
// Decodes one completed attribute from the collected value words.
// ----------------------------------------------------------------------------
`default_nettype none
module smp_attr_decode #(
    parameter int STRING_MAX = smp_pkg::STRING_MAX_DEF
) (
    input  wire logic [15:0] attr_type,
    input  wire logic [15:0] attr_len,
    input  wire logic [31:0] word0,
    input  wire logic [63:0] acc_high,
    input  wire logic [63:0] acc_low,
    input  wire logic [31:0] txid_upper,
    input  wire logic [63:0] txid_lower,
    output smp_pkg::out_item_t item,
    output logic             bad
);
    import smp_pkg::*;

    localparam logic [15:0] STR_LIM = 16'(STRING_MAX - 1);

    logic       x;
    logic [7:0] fam;

    always_comb
    begin
        item = '0;
        item.result_kind = KIND_ATTR;
        item.type_code = attr_type;
        item.length_field = attr_len;
        bad = 1'b0;
        x = (attr_type != AT_MAPPED);
        fam = word0[23:16];
        case (attr_type)
            AT_MAPPED, AT_XMAPPED, AT_XRELAY, AT_XPEER:
            begin
                if (attr_len < 16'd8 || word0[31:24] != 8'd0)
                    bad = 1'b1;
                else
                begin
                    item.family = fam;
                    item.port = word0[15:0] ^ (x ? COOKIE[31:16] : 16'd0);
                    if (fam == 8'd1)
                        item.value_high = {32'd0, acc_high[63:32] ^ (x ? COOKIE : 32'd0)};
                    else if (fam == 8'd2)
                    begin
                        if (attr_len < 16'd20)
                            bad = 1'b1;
                        else
                        begin
                            item.value_high = acc_high ^ (x ? {COOKIE, txid_upper} : 64'd0);
                            item.value_low = acc_low ^ (x ? txid_lower : 64'd0);
                        end
                    end
                end
            end
            AT_USER, AT_REALM, AT_NONCE, AT_SOFTWARE:
                bad = (attr_len > STR_LIM);
            AT_ERROR, AT_FPRINT, AT_PRIORITY, AT_LIFETIME:
            begin
                if (attr_len < 16'd4)
                    bad = 1'b1;
                else
                    item.value_high = {32'd0, word0};
            end
            AT_REQTRANS:
            begin
                if (attr_len < 16'd4)
                    bad = 1'b1;
                else
                    item.value_high = {56'd0, word0[31:24]};
            end
            AT_MSGINT:
                bad = (attr_len != 16'd20);
            AT_ICECTL, AT_ICECTD:
            begin
                if (attr_len >= 16'd8)
                    item.value_high = {word0, acc_high[63:32]};
            end
            AT_USECAND, AT_DATA:
                bad = 1'b0;
            default:
                bad = 1'b1;
        endcase
        if (bad)
        begin
            item.family = '0;
            item.port = '0;
            item.value_high = '0;
            item.value_low = '0;
        end
    end

endmodule
`default_nettype wire
